FILE: hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, field widths and field positions of the sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int FRAME_W     = 16;
   localparam int DUR_W       = 24;
   localparam int DELTA_W     = 24;
   localparam int ELAPSED_W   = 25;
   localparam int SEQ_FIELD_W = 4;
   localparam int CELL_FIELD_W = 4;
   localparam int LEN_FIELD_W = 5;
   localparam int OP_W        = 2;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 24;

   localparam int DELTA_LSB   = 0;
   localparam int SEQ_LSB     = 24;
   localparam int CELL_LSB    = 28;
   localparam int FRAME_LSB   = 32;
   localparam int DUR_LSB     = 48;
   localparam int LEN_LSB     = 72;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_LENGTH = 2'd2,
      OP_SELECT = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN_WAIT,
      ST_RD,
      ST_FIN,
      ST_CHK,
      ST_SUM,
      ST_MOD,
      ST_STEP_RD,
      ST_STEP_CHK
   } state_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [DUR_W-1:0]   dur;
   } cell_type;

   typedef struct packed {
      logic                    valid;
      logic [SEQ_FIELD_W-1:0]  active_seq;
      logic [CELL_FIELD_W-1:0] cell_pos;
      logic [FRAME_W-1:0]      frame;
   } rsp_type;

endpackage

FILE: hdl/sfs_cell_mem.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer cell memory
// Holds the frame id and duration of every cell, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module sfs_cell_mem
   import sfs_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_type          rd_data
);

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sfs_len_mem.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer length memory
// Holds the cell count of every sequence; a per-entry valid bit makes
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module sfs_len_mem
   import sfs_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic              rd_valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: hdl/sfs_mod_unit.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer remainder unit
// Restoring remainder of the elapsed time by the sequence cycle total,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfs_mod_unit
   import sfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ELAPSED_W-1:0] dividend,
   input  logic [ELAPSED_W-1:0] divisor,
   output logic                 done,
   output logic [ELAPSED_W-1:0] remainder
);

   localparam int CNT_W = $clog2(ELAPSED_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ELAPSED_W-1:0] rem_ff, rem_in;
   logic [ELAPSED_W-1:0] dvd_ff, dvd_in;
   logic [ELAPSED_W-1:0] dvs_ff, dvs_in;
   logic [ELAPSED_W:0]   shifted;
   logic [ELAPSED_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[ELAPSED_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ELAPSED_W);
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = (shifted >= {1'b0, dvs_ff}) ? diff[ELAPSED_W-1:0]
                                              : shifted[ELAPSED_W-1:0];
         dvd_in = {dvd_ff[ELAPSED_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/sprite_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer core
// Animation frame timer over a table of sequences of timed cells.
// ----------------------------------------------------------------------------
// Every transaction on the request side gives exactly one response transaction
// with the frame id and cell position of the active sequence after the
// operation. Table writes, length writes and ticks that do not change the cell
// read the current cell and then load the response; a select first reads the
// length memory. A tick that reaches the end of the current cell first sums
// the durations of the active sequence and then walks the cells, one read of
// the single cell memory port per cell. When the elapsed time covers a whole
// pass of the sequence and no cell has zero duration, the one-bit-per-cycle
// remainder unit reduces it before the walk. A new request is taken while the
// previous response still waits in the output register.
module sprite_frame_sequencer_core
   import sfs_pkg::*;
#(
   parameter int NUM_SEQS  = 16,
   parameter int MAX_CELLS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // delta, seq_sel, cell_sel, frame_in, duration_in, length_in, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_out, cell_pos, active_seq
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // valid_res
   output logic [0:0]            rsp_tuser
);

   localparam int SEQ_W  = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
   localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int LEN_W  = $clog2(MAX_CELLS + 1);
   localparam int DEPTH  = NUM_SEQS * MAX_CELLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TOT_W  = DUR_W + $clog2(MAX_CELLS);
   localparam int CMP_W  = (TOT_W > ELAPSED_W) ? TOT_W : ELAPSED_W;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [SEQ_FIELD_W-1:0] seq,
                                                   input logic [CELL_W-1:0] slot);
      cell_addr = ADDR_W'(ADDR_W'(seq) * ADDR_W'(MAX_CELLS)) + ADDR_W'(slot);
   endfunction

   logic [DELTA_W-1:0]      req_delta;
   logic [SEQ_FIELD_W-1:0]  req_seq_sel;
   logic [CELL_FIELD_W-1:0] req_cell_sel;
   logic [FRAME_W-1:0]      req_frame_in;
   logic [DUR_W-1:0]        req_duration_in;
   logic [LEN_FIELD_W-1:0]  req_length_in;
   op_type                  req_op;
   logic                    seq_ok;
   logic                    cell_ok;
   logic [LEN_W-1:0]        len_sat;
   logic [ELAPSED_W:0]      elapsed_sum;
   logic [LEN_W-1:0]        cell_next;

   state_type               state_ff, state_in;
   logic [SEQ_FIELD_W-1:0]  cur_seq_ff, cur_seq_in;
   logic [CELL_W-1:0]       cur_cell_ff, cur_cell_in;
   logic [LEN_W-1:0]        active_len_ff, active_len_in;
   logic [ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic [LEN_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    acc_vld_ff, acc_vld_in;
   logic [TOT_W-1:0]        sum_ff, sum_in;
   logic                    any_zero_ff, any_zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    rsp_load;

   logic                    cm_wr_en;
   cell_type                cm_wr_data;
   logic                    cm_rd_en;
   logic [CELL_W-1:0]       cm_rd_cell;
   cell_type                cm_rd_data;
   logic                    lm_wr_en;
   logic                    lm_rd_en;
   logic [LEN_W-1:0]        lm_rd_data;
   logic                    mod_start;
   logic                    mod_done;
   logic [ELAPSED_W-1:0]    mod_rem;
   logic                    cell_stop;

   assign req_delta       = req_tdata[DELTA_LSB +: DELTA_W];
   assign req_seq_sel     = req_tdata[SEQ_LSB +: SEQ_FIELD_W];
   assign req_cell_sel    = req_tdata[CELL_LSB +: CELL_FIELD_W];
   assign req_frame_in    = req_tdata[FRAME_LSB +: FRAME_W];
   assign req_duration_in = req_tdata[DUR_LSB +: DUR_W];
   assign req_length_in   = req_tdata[LEN_LSB +: LEN_FIELD_W];
   assign req_op          = op_type'(req_tuser);

   assign seq_ok      = 32'(req_seq_sel) < NUM_SEQS;
   assign cell_ok     = 32'(req_cell_sel) < MAX_CELLS;
   assign len_sat     = (32'(req_length_in) > MAX_CELLS) ? LEN_W'(MAX_CELLS)
                                                         : LEN_W'(req_length_in);
   assign elapsed_sum = {1'b0, elapsed_ff} + (ELAPSED_W + 1)'(req_delta);
   assign cell_next   = LEN_W'(cur_cell_ff) + 1'b1;
   assign cell_stop   = (cm_rd_data.dur == '0) ||
                        (elapsed_ff < ELAPSED_W'(cm_rd_data.dur));
   assign cm_wr_data  = '{frame: req_frame_in, dur: req_duration_in};
   assign req_tready  = (state_ff == ST_IDLE);

   sfs_cell_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (cell_addr(req_seq_sel, CELL_W'(req_cell_sel))),
      .wr_data (cm_wr_data),
      .rd_en   (cm_rd_en),
      .rd_addr (cell_addr(cur_seq_ff, cm_rd_cell)),
      .rd_data (cm_rd_data)
   );

   sfs_len_mem #(
      .DEPTH  (NUM_SEQS),
      .ADDR_W (SEQ_W),
      .DATA_W (LEN_W)
   ) u_len_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (lm_wr_en),
      .wr_addr (SEQ_W'(req_seq_sel)),
      .wr_data (len_sat),
      .rd_en   (lm_rd_en),
      .rd_addr (SEQ_W'(req_seq_sel)),
      .rd_data (lm_rd_data)
   );

   sfs_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (elapsed_ff),
      .divisor   (ELAPSED_W'(sum_ff)),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in      = state_ff;
      cur_seq_in    = cur_seq_ff;
      cur_cell_in   = cur_cell_ff;
      active_len_in = active_len_ff;
      elapsed_in    = elapsed_ff;
      rd_idx_in     = rd_idx_ff;
      acc_vld_in    = acc_vld_ff;
      sum_in        = sum_ff;
      any_zero_in   = any_zero_ff;
      cm_wr_en      = 1'b0;
      cm_rd_en      = 1'b0;
      cm_rd_cell    = cur_cell_ff;
      lm_wr_en      = 1'b0;
      lm_rd_en      = 1'b0;
      mod_start     = 1'b0;
      rsp_load      = 1'b0;
      rsp_data_in   = '0;
      rsp_data_in.active_seq = cur_seq_ff;
      if (active_len_ff != '0) begin
         rsp_data_in.valid    = 1'b1;
         rsp_data_in.cell_pos = CELL_FIELD_W'(cur_cell_ff);
         rsp_data_in.frame    = cm_rd_data.frame;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RD;
               case (req_op)
                  OP_TICK: begin
                     if (active_len_ff != '0) begin
                        elapsed_in = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX
                                                            : elapsed_sum[ELAPSED_W-1:0];
                        cm_rd_en   = 1'b1;
                        state_in   = ST_CHK;
                     end
                  end
                  OP_WRITE: begin
                     cm_wr_en = seq_ok && cell_ok;
                  end
                  OP_LENGTH: begin
                     if (seq_ok) begin
                        lm_wr_en = 1'b1;
                        if (req_seq_sel == cur_seq_ff) begin
                           active_len_in = len_sat;
                           if (LEN_W'(cur_cell_ff) >= len_sat) begin
                              cur_cell_in = '0;
                           end
                        end
                     end
                  end
                  OP_SELECT: begin
                     if (seq_ok) begin
                        lm_rd_en    = 1'b1;
                        cur_seq_in  = req_seq_sel;
                        cur_cell_in = '0;
                        elapsed_in  = '0;
                        state_in    = ST_LEN_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_RD;
                  end
               endcase
            end
         end
         ST_LEN_WAIT: begin
            active_len_in = lm_rd_data;
            state_in      = ST_RD;
         end
         ST_RD: begin
            cm_rd_en = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (cell_stop) begin
               state_in = ST_FIN;
            end else begin
               rd_idx_in   = '0;
               acc_vld_in  = 1'b0;
               sum_in      = '0;
               any_zero_in = 1'b0;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            acc_vld_in = 1'b0;
            if (rd_idx_ff < active_len_ff) begin
               cm_rd_en   = 1'b1;
               cm_rd_cell = rd_idx_ff[CELL_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
               acc_vld_in = 1'b1;
            end
            if (acc_vld_ff) begin
               sum_in      = sum_ff + TOT_W'(cm_rd_data.dur);
               any_zero_in = any_zero_ff || (cm_rd_data.dur == '0);
            end
            if ((rd_idx_ff == active_len_ff) && !acc_vld_ff) begin
               if (!any_zero_ff && (CMP_W'(elapsed_ff) >= CMP_W'(sum_ff))) begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end else begin
                  state_in = ST_STEP_RD;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               elapsed_in = mod_rem;
               state_in   = ST_STEP_RD;
            end
         end
         ST_STEP_RD: begin
            cm_rd_en = 1'b1;
            state_in = ST_STEP_CHK;
         end
         ST_STEP_CHK: begin
            if (cell_stop) begin
               state_in = ST_FIN;
            end else begin
               elapsed_in  = elapsed_ff - ELAPSED_W'(cm_rd_data.dur);
               cur_cell_in = (cell_next >= active_len_ff) ? '0 : cell_next[CELL_W-1:0];
               state_in    = ST_STEP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_seq_ff    <= '0;
         cur_cell_ff   <= '0;
         active_len_ff <= '0;
         elapsed_ff    <= '0;
         acc_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_seq_ff    <= cur_seq_in;
         cur_cell_ff   <= cur_cell_in;
         active_len_ff <= active_len_in;
         elapsed_ff    <= elapsed_in;
         acc_vld_ff    <= acc_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      sum_ff      <= sum_in;
      any_zero_ff <= any_zero_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_data_ff.active_seq, rsp_data_ff.cell_pos, rsp_data_ff.frame};
   assign rsp_tuser[0] = rsp_data_ff.valid;

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      (active_len_ff != '0) |-> (LEN_W'(cur_cell_ff) < active_len_ff))
      else $error("current cell lies beyond the active sequence length");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(active_len_ff) <= MAX_CELLS)
      else $error("active sequence length exceeds the cell capacity");

   a_mod_reduces: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_STEP_RD) && ($past(state_ff) == ST_MOD))
         |-> (CMP_W'(elapsed_ff) < CMP_W'(sum_ff)))
      else $error("remainder is not below the sequence cycle total");

   a_mod_done_owned: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("remainder unit finished while no tick waits for it");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives table writes, length writes, selects and ticks into the sequencer
// core, first from a short directed table and then at random in four idling
// phases, and checks each response against a set value or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb
   import sfs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SEQS    = 16;
   localparam int MAX_CELLS   = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 112;
   localparam int TAIL_CYCLES = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT     = 40;

   typedef struct packed {
      logic [LEN_FIELD_W-1:0]  len;
      logic [DUR_W-1:0]        dur;
      logic [FRAME_W-1:0]      frame;
      logic [CELL_FIELD_W-1:0] slot;
      logic [SEQ_FIELD_W-1:0]  seq;
      logic [DELTA_W-1:0]      delta;
   } req_fields_type;

   typedef struct {
      op_type         op;
      req_fields_type f;
      bit             typed;
      rsp_type        want;
   } plan_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = OP_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   // Predictor state.
   logic [FRAME_W-1:0]      frame_mem [NUM_SEQS*MAX_CELLS];
   logic [DUR_W-1:0]        dur_mem [NUM_SEQS*MAX_CELLS];
   bit                      cell_written [NUM_SEQS*MAX_CELLS];
   logic [LEN_FIELD_W-1:0]  seq_len [NUM_SEQS];
   logic [SEQ_FIELD_W-1:0]  cur_seq   = '0;
   logic [CELL_FIELD_W-1:0] cur_cell  = '0;
   logic [ELAPSED_W-1:0]    elapsed_q = '0;

   rsp_type      predicted_frames [$];
   plan_row_type plan [$];
   int           mismatches     = 0;
   int           results_seen   = 0;
   int           cycle_count    = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           hold_left      = 0;
   bit           hold_done      = 1'b0;
   rsp_type      seen_view;
   rsp_type      oldest_view;

   sprite_frame_sequencer_core #(
      .NUM_SEQS  (NUM_SEQS),
      .MAX_CELLS (MAX_CELLS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      foreach (seq_len[i]) seq_len[i] = '0;
   end

   function automatic rsp_type step_animation(input op_type op, input req_fields_type f);
      logic [LEN_FIELD_W-1:0] len;
      logic [63:0]            e;
      logic [63:0]            total;
      logic [DUR_W-1:0]       d;
      bit                     has_hold;
      rsp_type                r;
      case (op)
         OP_TICK: begin
            len = seq_len[cur_seq];
            if (len != 0) begin
               e = 64'(elapsed_q) + 64'(f.delta);
               if (e > 64'(ELAPSED_MAX)) e = 64'(ELAPSED_MAX);
               total = '0;
               has_hold = 1'b0;
               for (int i = 0; i < len; i++) begin
                  d = dur_mem[{cur_seq, 4'(i)}];
                  if (d == 0) has_hold = 1'b1;
                  total += 64'(d);
               end
               // Whole passes over the sequence change nothing but the time.
               if (!has_hold && total != 0 && e >= total) e = e % total;
               for (int s = 0; s <= len; s++) begin
                  d = dur_mem[{cur_seq, cur_cell}];
                  if (d == 0 || e < 64'(d)) break;
                  e -= 64'(d);
                  if ({1'b0, cur_cell} + 5'd1 >= len) cur_cell = '0;
                  else cur_cell = cur_cell + 4'd1;
               end
               elapsed_q = e[ELAPSED_W-1:0];
            end
         end
         OP_WRITE: begin
            frame_mem[{f.seq, f.slot}] = f.frame;
            dur_mem[{f.seq, f.slot}] = f.dur;
            cell_written[{f.seq, f.slot}] = 1'b1;
         end
         OP_LENGTH: begin
            len = (f.len > MAX_CELLS) ? LEN_FIELD_W'(MAX_CELLS) : f.len;
            seq_len[f.seq] = len;
            if (f.seq == cur_seq && {1'b0, cur_cell} >= len) cur_cell = '0;
         end
         default: begin
            cur_seq = f.seq;
            cur_cell = '0;
            elapsed_q = '0;
         end
      endcase
      r = '0;
      r.active_seq = cur_seq;
      if (seq_len[cur_seq] != 0) begin
         r.valid = 1'b1;
         r.cell_pos = cur_cell;
         r.frame = frame_mem[{cur_seq, cur_cell}];
      end
      return r;
   endfunction

   // Number of cells written without a gap from cell 0 up.
   function automatic int written_run(input logic [SEQ_FIELD_W-1:0] seq);
      int n;
      n = 0;
      while (n < MAX_CELLS && cell_written[{seq, 4'(n)}]) n++;
      return n;
   endfunction

   task automatic add_row(input op_type op, input logic [3:0] seq, input logic [3:0] slot,
                          input logic [15:0] frame, input logic [23:0] dur,
                          input logic [4:0] len, input logic [23:0] delta,
                          input bit typed, input rsp_type want);
      req_fields_type f;
      plan_row_type   row;
      f = '{len: len, dur: dur, frame: frame, slot: slot, seq: seq, delta: delta};
      row.op    = op;
      row.f     = f;
      row.typed = typed;
      row.want  = want;
      plan.insert(plan.size(), row);
   endtask

   task automatic pick_request(output op_type op, output req_fields_type f);
      int roll;
      int pick;
      int run;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      f.delta = DELTA_W'($urandom);
      f.seq   = SEQ_FIELD_W'($urandom);
      f.slot  = CELL_FIELD_W'($urandom);
      f.frame = FRAME_W'($urandom);
      f.dur   = DUR_W'($urandom);
      f.len   = LEN_FIELD_W'($urandom);
      if (roll < 50) begin
         op = OP_TICK;
         if (pick < 80) f.delta = DELTA_W'($urandom_range(6000));
         else if (pick < 90) f.delta = '0;
      end else if (roll < 75) begin
         op = OP_WRITE;
         if ($urandom_range(9) < 8) f.seq = SEQ_FIELD_W'($urandom_range(3));
         run = written_run(f.seq);
         if (run < MAX_CELLS && $urandom_range(9) < 7) f.slot = CELL_FIELD_W'(run);
         if (pick < 8) f.dur = '0;
         else if (pick < 92) f.dur = DUR_W'($urandom_range(4000, 1));
      end else if (roll < 87) begin
         op = OP_LENGTH;
         if ($urandom_range(9) < 8) f.seq = SEQ_FIELD_W'($urandom_range(3));
         run = written_run(f.seq);
         if (run == MAX_CELLS && $urandom_range(3) == 0) begin
            f.len = LEN_FIELD_W'($urandom_range(31, MAX_CELLS + 1));
         end else if ($urandom_range(1) == 1) begin
            f.len = LEN_FIELD_W'(run);
         end else begin
            f.len = LEN_FIELD_W'($urandom_range(run));
         end
      end else begin
         op = OP_SELECT;
         if ($urandom_range(9) < 8) f.seq = SEQ_FIELD_W'($urandom_range(3));
      end
   endtask

   task automatic send(input op_type op, input req_fields_type f, input bit typed,
                       input rsp_type want);
      rsp_type model_view;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(f);
      do @(posedge clock); while (req_tready !== 1'b1);
      model_view = step_animation(op, f);
      predicted_frames.insert(predicted_frames.size(), typed ? want : model_view);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (predicted_frames.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      op_type         op;
      req_fields_type f;
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'hFFFFFF, 1,
              {1'b0, 4'd0, 4'd0, 16'h0000});
      add_row(OP_SELECT, 4'd15, 4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_LENGTH, 4'd15, 4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_WRITE,  4'd0,  4'd0,  16'hFFFF, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_WRITE,  4'd0,  4'd1,  16'h0001, 24'hFFFFFF, 5'd0, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_WRITE,  4'd0,  4'd2,  16'h1234, 24'h000001, 5'd0, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_LENGTH, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd3, 24'h000000, 1,
              {1'b0, 4'd15, 4'd0, 16'h0000});
      add_row(OP_SELECT, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b1, 4'd0, 4'd0, 16'hFFFF});
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'hFFFFFF, 1,
              {1'b1, 4'd0, 4'd0, 16'hFFFF});
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'hFFFFFF, 1,
              {1'b1, 4'd0, 4'd0, 16'hFFFF});
      add_row(OP_WRITE,  4'd0,  4'd0,  16'hABCD, 24'h000002, 5'd0, 24'h000000, 0, '0);
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 0, '0);
      add_row(OP_LENGTH, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd1, 24'h000000, 0, '0);
      add_row(OP_LENGTH, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd3, 24'h000000, 0, '0);
      add_row(OP_SELECT, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b1, 4'd0, 4'd0, 16'hABCD});
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000002, 0, '0);
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'hFFFFFF, 0, '0);
      add_row(OP_WRITE,  4'd15, 4'd15, 16'h5A5A, 24'h000007, 5'd31, 24'h000000, 0, '0);
      add_row(OP_LENGTH, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000000, 1,
              {1'b0, 4'd0, 4'd0, 16'h0000});
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h000007, 1,
              {1'b0, 4'd0, 4'd0, 16'h0000});
      add_row(OP_LENGTH, 4'd0,  4'd0,  16'h0000, 24'h000000, 5'd3, 24'h000000, 0, '0);
      add_row(OP_TICK,   4'd0,  4'd0,  16'h0000, 24'h000000, 5'd0, 24'h800000, 0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send(plan[i].op, plan[i].f, plan[i].typed, plan[i].want);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_request(op, f);
            send(op, f, 1'b0, '0);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_frames.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // The long hold-off lets the core fill up and push back on the request side.
   always @(posedge clock) begin
      if (!hold_done && results_seen == HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_view = {rsp_tuser, rsp_tdata};
         results_seen <= results_seen + 1;
         if (predicted_frames.size() == 0) begin
            $display("%0t: response with nothing expected, got %h", $time, seen_view);
            mismatches++;
         end else begin
            oldest_view = predicted_frames.pop_front();
            report_field("frame_out", oldest_view.frame, seen_view.frame);
            report_field("cell_pos", 16'(oldest_view.cell_pos), 16'(seen_view.cell_pos));
            report_field("active_seq", 16'(oldest_view.active_seq),
                         16'(seen_view.active_seq));
            report_field("valid_res", 16'(oldest_view.valid), 16'(seen_view.valid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
